>>> design/cepstral_delta_features_unit_macros.svh
// Assertion macros shared by the delta cepstrum unit's modules.
`ifndef CEPSTRAL_DELTA_FEATURES_UNIT_MACROS_SVH
`define CEPSTRAL_DELTA_FEATURES_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CDF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cdf: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CDF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cdf: next-cycle check failed");

`endif

>>> design/cdf_pkg.sv
// Types and constants shared by the delta cepstrum unit.
package cdf_pkg;

  localparam int FRAME_W     = 16;
  localparam int COEF_W      = 5;
  localparam int CEP_W       = 16;
  localparam int DELTA_W     = 17;
  localparam int CFG_W       = 6;
  // Wide enough for a back offset of up to fifteen frames.
  localparam int BACK_W      = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0] COEF_COUNT_RESET = 6'd13;

  // One classified word as it waits between the front and the back.
  typedef struct packed {
    logic [FRAME_W-1:0]        frame;
    logic [COEF_W-1:0]         coef;
    logic signed [DELTA_W-1:0] delta;
    logic                      short_err;
    logic                      end_flag;
    logic [BACK_W-1:0]         back_first;
    logic [BACK_W-1:0]         back_last;
  } cmd_t;

endpackage

>>> design/cdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cdf_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [DATA_W-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [DATA_W-1:0]                       rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/cdf_front.sv
// Front end: accepts coefficient words, keeps the frame history and classifies each word.
`include "cepstral_delta_features_unit_macros.svh"

module cdf_front #(
  parameter int MAX_COEFS   = 32,
  parameter int HALF_WINDOW = 2
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  output logic                                          full,
  input  logic signed [cdf_pkg::CEP_W-1:0]              in_cep_value,
  input  logic                                          in_final_frame,
  input  logic                                          cfg_wr_en,
  input  logic [cdf_pkg::CFG_W-1:0]                     cfg_wr_data,
  input  logic [cdf_pkg::LEVEL_W-1:0]                   q_level,
  output logic                                          q_push,
  output cdf_pkg::cmd_t                                 q_cmd,
  output logic [2*HALF_WINDOW:0][cdf_pkg::CEP_W-1:0]    q_vals
);

  localparam int SLOTS = 2 * HALF_WINDOW;
  localparam int HPW   = $clog2(SLOTS);
  localparam int AW    = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
  localparam int NW    = ($clog2(MAX_COEFS + 1) > 6) ? $clog2(MAX_COEFS + 1) : 6;

  logic [cdf_pkg::CFG_W-1:0]   coef_count_r;
  logic [cdf_pkg::COEF_W-1:0]  coef_cnt_r, coef_cnt_nxt;
  logic [cdf_pkg::FRAME_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic [HPW-1:0]              hist_ptr_r, hist_ptr_nxt;
  logic                        enough_r, enough_nxt;

  logic                              s1_valid_r;
  logic [cdf_pkg::FRAME_W-1:0]       s1_frame_r;
  logic [cdf_pkg::COEF_W-1:0]        s1_coef_r;
  logic signed [cdf_pkg::CEP_W-1:0]  s1_cur_r;
  logic                              s1_short_r, s1_lead_r, s1_fin_r, s1_last_r;
  logic [HPW-1:0]                    s1_hp_r;

  logic                              accept;
  logic [NW-1:0]                     active_n;
  logic                              last;
  logic                              short_case;
  logic                              lead_case;
  logic [AW-1:0]                     addr;
  logic [SLOTS-1:0][cdf_pkg::CEP_W-1:0] rd_data;

  assign full   = ({1'b0, q_level} + (cdf_pkg::LEVEL_W + 1)'(s1_valid_r))
                  >= (cdf_pkg::LEVEL_W + 1)'(cdf_pkg::QUEUE_DEPTH);
  assign accept = push && !full;

  // Zero coefficients act as one, and anything above the store as its size.
  always_comb begin
    if (coef_count_r == '0) begin
      active_n = NW'(1);
    end else if (NW'(coef_count_r) > NW'(MAX_COEFS)) begin
      active_n = NW'(MAX_COEFS);
    end else begin
      active_n = NW'(coef_count_r);
    end
  end

  assign last       = (NW'(coef_cnt_r) + NW'(1)) >= active_n;
  assign short_case = !enough_r && (frame_cnt_r < cdf_pkg::FRAME_W'(SLOTS));
  assign lead_case  = !enough_r && (frame_cnt_r == cdf_pkg::FRAME_W'(SLOTS));
  assign addr       = AW'(coef_cnt_r);

  always_comb begin
    coef_cnt_nxt  = coef_cnt_r;
    frame_cnt_nxt = frame_cnt_r;
    hist_ptr_nxt  = hist_ptr_r;
    enough_nxt    = enough_r;
    if (accept) begin
      if (!last) begin
        coef_cnt_nxt = coef_cnt_r + cdf_pkg::COEF_W'(1);
      end else begin
        coef_cnt_nxt = '0;
        if (in_final_frame) begin
          frame_cnt_nxt = '0;
          hist_ptr_nxt  = '0;
          enough_nxt    = 1'b0;
        end else begin
          if (frame_cnt_r >= cdf_pkg::FRAME_W'(SLOTS)) begin
            enough_nxt = 1'b1;
          end
          frame_cnt_nxt = frame_cnt_r + cdf_pkg::FRAME_W'(1);
          hist_ptr_nxt  = (hist_ptr_r == HPW'(SLOTS - 1)) ? '0 : hist_ptr_r + HPW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_count_r <= cdf_pkg::COEF_COUNT_RESET;
      coef_cnt_r   <= '0;
      frame_cnt_r  <= '0;
      hist_ptr_r   <= '0;
      enough_r     <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        coef_count_r <= cfg_wr_data;
      end
      coef_cnt_r  <= coef_cnt_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      hist_ptr_r  <= hist_ptr_nxt;
      enough_r    <= enough_nxt;
      s1_valid_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_frame_r <= frame_cnt_r;
      s1_coef_r  <= coef_cnt_r;
      s1_cur_r   <= in_cep_value;
      s1_short_r <= short_case;
      s1_lead_r  <= lead_case;
      s1_fin_r   <= in_final_frame;
      s1_last_r  <= last;
      s1_hp_r    <= hist_ptr_r;
    end
  end

  // One history slot per past frame; all are read at the coefficient position.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    cdf_ram #(
      .DATA_W (cdf_pkg::CEP_W),
      .DEPTH  (MAX_COEFS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (accept && (hist_ptr_r == HPW'(s))),
      .wr_addr (addr),
      .wr_data (in_cep_value),
      .rd_addr (addr),
      .rd_data (rd_data[s])
    );
  end

  // Entry b of the value vector is the coefficient b frames back.
  always_comb begin
    logic [HPW:0] sl;
    sl        = '0;
    q_vals[0] = s1_cur_r;
    for (int b = 1; b <= SLOTS; b++) begin
      sl = (HPW + 1)'(s1_hp_r) + (HPW + 1)'(SLOTS - b);
      if (sl >= (HPW + 1)'(SLOTS)) begin
        sl = sl - (HPW + 1)'(SLOTS);
      end
      q_vals[b] = rd_data[sl[HPW-1:0]];
    end
  end

  always_comb begin
    q_cmd.frame     = s1_frame_r;
    q_cmd.coef      = s1_coef_r;
    q_cmd.delta     = s1_short_r ? '0 :
                      $signed({s1_cur_r[cdf_pkg::CEP_W-1], s1_cur_r})
                      - $signed({q_vals[SLOTS][cdf_pkg::CEP_W-1], q_vals[SLOTS]});
    q_cmd.short_err = s1_short_r;
    q_cmd.end_flag  = s1_fin_r && s1_last_r;
    q_cmd.back_first = (s1_short_r || s1_lead_r) ? cdf_pkg::BACK_W'(s1_frame_r)
                                                 : cdf_pkg::BACK_W'(HALF_WINDOW);
    q_cmd.back_last  = s1_fin_r ? '0 : cdf_pkg::BACK_W'(HALF_WINDOW);
  end

  // A word of a short utterance before its final frame causes no result.
  assign q_push = s1_valid_r && !(s1_short_r && !s1_fin_r);

  `CDF_ASSERT_IMP(a_ptr_range, 1'b1, (HPW + 1)'(hist_ptr_r) < (HPW + 1)'(SLOTS))
  `CDF_ASSERT_IMP(a_fresh_utt, (frame_cnt_r == '0) && !enough_r, hist_ptr_r == '0)

endmodule

>>> design/cdf_queue.sv
// Short register queue between the front end and the result sequencer.
`include "cepstral_delta_features_unit_macros.svh"

module cdf_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [WIDTH-1:0]                 push_data,
  input  logic                             pop,
  output logic [WIDTH-1:0]                 pop_data,
  output logic                             empty,
  output logic [$clog2(DEPTH + 1)-1:0]     level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] mem_r;
  logic [PW-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]               level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (level_r == '0);
  assign level    = level_r;

  // The front end reserves room, so a push never meets a full queue.
  `CDF_ASSERT_IMP(a_no_overflow, push, level_r != LW'(DEPTH))
  `CDF_ASSERT_NXT(a_drain, pop && !push && (level_r == LW'(1)), empty)

endmodule

>>> design/cdf_back.sv
// Result sequencer: expands each queued word into its results and holds the output word.
`include "cepstral_delta_features_unit_macros.svh"

module cdf_back #(
  parameter int HALF_WINDOW = 2
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          q_empty,
  input  cdf_pkg::cmd_t                                 q_cmd,
  input  logic [2*HALF_WINDOW:0][cdf_pkg::CEP_W-1:0]    q_vals,
  output logic                                          q_pop,
  output logic                                          empty,
  input  logic                                          pop,
  output logic [cdf_pkg::FRAME_W-1:0]                   out_frame_index,
  output logic [cdf_pkg::COEF_W-1:0]                    out_coef_index,
  output logic signed [cdf_pkg::CEP_W-1:0]              out_cep_out,
  output logic signed [cdf_pkg::DELTA_W-1:0]            out_delta_out,
  output logic                                          out_utterance_end,
  output logic                                          out_short_error
);

  localparam int SLOTS = 2 * HALF_WINDOW;
  localparam int BW    = $clog2(SLOTS + 1);

  logic                              mid_r, mid_nxt;
  logic [BW-1:0]                     back_r, back_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [cdf_pkg::FRAME_W-1:0]       frame_r;
  logic [cdf_pkg::COEF_W-1:0]        coef_r;
  logic [cdf_pkg::CEP_W-1:0]         cep_r;
  logic signed [cdf_pkg::DELTA_W-1:0] delta_r;
  logic                              end_r, short_r;

  logic          load;
  logic          done;
  logic [BW-1:0] cur_b;

  assign cur_b = mid_r ? back_r : q_cmd.back_first[BW-1:0];
  assign load  = !q_empty && (!out_valid_r || pop);
  assign done  = (cur_b == q_cmd.back_last[BW-1:0]);
  assign q_pop = load && done;

  always_comb begin
    mid_nxt  = mid_r;
    back_nxt = back_r;
    if (load) begin
      mid_nxt  = !done;
      back_nxt = cur_b - BW'(1);
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= 1'b0;
      back_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mid_r       <= mid_nxt;
      back_r      <= back_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= q_cmd.frame - cdf_pkg::FRAME_W'(cur_b);
      coef_r  <= q_cmd.coef;
      cep_r   <= q_vals[cur_b];
      delta_r <= q_cmd.delta;
      end_r   <= q_cmd.end_flag && done;
      short_r <= q_cmd.short_err;
    end
  end

  assign empty             = !out_valid_r;
  assign out_frame_index   = frame_r;
  assign out_coef_index    = coef_r;
  assign out_cep_out       = cep_r;
  assign out_delta_out     = delta_r;
  assign out_utterance_end = end_r;
  assign out_short_error   = short_r;

  // Part way through a word, that word must still be at the head of the queue.
  `CDF_ASSERT_IMP(a_mid_has_word, mid_r, !q_empty)

endmodule

>>> design/cepstral_delta_features_unit.sv
// Top level of the delta cepstrum unit: front end, queue and result sequencer.
//
//   Channel  Handshake         Payload
//   input    push / full       in_cep_value, in_final_frame
//   result   empty / pop       out_frame_index, out_coef_index, out_cep_out,
//                              out_delta_out, out_utterance_end, out_short_error
//   config   cfg_wr_en         cfg_wr_data (coefficients per frame)
//
// One input word is taken per cycle while full is low. Each word gives zero
// to 2*HALF_WINDOW+1 results, and the sequencer hands out one result per
// cycle while the output is popped or empty; a word stays at the queue head
// until its last result is loaded into the output register.
// Reset is synchronous and active low; it clears counters, pointers and the
// queue at once. The history RAMs are not cleared.
// full rises while the four-word queue plus the word in the classify stage
// would leave no room; a stalled result simply holds in the output register.
module cepstral_delta_features_unit #(
  parameter int MAX_COEFS   = 32,
  parameter int HALF_WINDOW = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [cdf_pkg::CEP_W-1:0]    in_cep_value,
  input  logic                                in_final_frame,
  output logic                                empty,
  input  logic                                pop,
  output logic [cdf_pkg::FRAME_W-1:0]         out_frame_index,
  output logic [cdf_pkg::COEF_W-1:0]          out_coef_index,
  output logic signed [cdf_pkg::CEP_W-1:0]    out_cep_out,
  output logic signed [cdf_pkg::DELTA_W-1:0]  out_delta_out,
  output logic                                out_utterance_end,
  output logic                                out_short_error,
  input  logic                                cfg_wr_en,
  input  logic [cdf_pkg::CFG_W-1:0]           cfg_wr_data
);

  localparam int SLOTS = 2 * HALF_WINDOW;
  localparam int QW    = $bits(cdf_pkg::cmd_t) + (SLOTS + 1) * cdf_pkg::CEP_W;

  // Words cross from the front end to the back end through the queue, each
  // carrying its classification and the coefficient of every frame it spans.
  logic                                 q_push;
  cdf_pkg::cmd_t                        push_cmd;
  logic [SLOTS:0][cdf_pkg::CEP_W-1:0]   push_vals;
  logic [QW-1:0]                        push_data;
  logic [QW-1:0]                        pop_data;
  cdf_pkg::cmd_t                        head_cmd;
  logic [SLOTS:0][cdf_pkg::CEP_W-1:0]   head_vals;
  logic                                 q_pop;
  logic                                 q_empty;
  logic [cdf_pkg::LEVEL_W-1:0]          q_level;

  cdf_front #(
    .MAX_COEFS   (MAX_COEFS),
    .HALF_WINDOW (HALF_WINDOW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_cep_value   (in_cep_value),
    .in_final_frame (in_final_frame),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_level        (q_level),
    .q_push         (q_push),
    .q_cmd          (push_cmd),
    .q_vals         (push_vals)
  );

  assign push_data = {push_cmd, push_vals};

  cdf_queue #(
    .WIDTH (QW),
    .DEPTH (cdf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty),
    .level     (q_level)
  );

  assign {head_cmd, head_vals} = pop_data;

  cdf_back #(
    .HALF_WINDOW (HALF_WINDOW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_cmd             (head_cmd),
    .q_vals            (head_vals),
    .q_pop             (q_pop),
    .empty             (empty),
    .pop               (pop),
    .out_frame_index   (out_frame_index),
    .out_coef_index    (out_coef_index),
    .out_cep_out       (out_cep_out),
    .out_delta_out     (out_delta_out),
    .out_utterance_end (out_utterance_end),
    .out_short_error   (out_short_error)
  );

endmodule

>>> tb/sv/tb_cepstral_delta_features_unit.sv
// Self-checking testbench for the delta cepstrum unit with a built-in result predictor.
module tb_cepstral_delta_features_unit;

  // Window geometry of the block under test: two frames either side, so four
  // frames of history, each of up to 32 coefficients.
  localparam int HALF_WIN   = 2;
  localparam int SLOTS      = 2 * HALF_WIN;
  localparam int MAX_COEFS  = 32;
  // Cycles allowed for the pipeline to settle once the last result is out.
  localparam int SETTLE     = 20;
  localparam int DRAIN_SPIN = 20000;
  localparam int RAND_WORDS = 100;

  // One expected result, laid out as the block presents it.
  typedef struct packed {
    logic [cdf_pkg::FRAME_W-1:0]        frame;
    logic [cdf_pkg::COEF_W-1:0]         coef;
    logic signed [cdf_pkg::CEP_W-1:0]   cep;
    logic signed [cdf_pkg::DELTA_W-1:0] delta;
    logic                               uend;
    logic                               serr;
  } feature_t;

  logic                               clk;
  logic                               rst_n;
  logic                               push;
  logic                               full;
  logic signed [cdf_pkg::CEP_W-1:0]   in_cep_value;
  logic                               in_final_frame;
  logic                               empty;
  logic                               pop;
  logic [cdf_pkg::FRAME_W-1:0]        out_frame_index;
  logic [cdf_pkg::COEF_W-1:0]         out_coef_index;
  logic signed [cdf_pkg::CEP_W-1:0]   out_cep_out;
  logic signed [cdf_pkg::DELTA_W-1:0] out_delta_out;
  logic                               out_utterance_end;
  logic                               out_short_error;
  logic                               cfg_wr_en;
  logic [cdf_pkg::CFG_W-1:0]          cfg_wr_data;

  // Predictor state: a private copy of the history, counters and the
  // coefficient count register.
  logic signed [cdf_pkg::CEP_W-1:0] cep_hist [SLOTS][MAX_COEFS];
  bit [cdf_pkg::FRAME_W-1:0]        frame_ctr;
  bit [cdf_pkg::COEF_W-1:0]         coef_ctr;
  bit [1:0]                         hist_slot;
  bit                               have_history;
  bit [cdf_pkg::CFG_W-1:0]          coef_cfg;

  feature_t pending_features[$];

  int  coef_words_sent;
  int  features_checked;
  int  mismatch_count;
  bit  idle_on;
  int  pop_stall;

  cepstral_delta_features_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_cep_value      (in_cep_value),
    .in_final_frame    (in_final_frame),
    .empty             (empty),
    .pop               (pop),
    .out_frame_index   (out_frame_index),
    .out_coef_index    (out_coef_index),
    .out_cep_out       (out_cep_out),
    .out_delta_out     (out_delta_out),
    .out_utterance_end (out_utterance_end),
    .out_short_error   (out_short_error),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The register is six bits wide, but zero behaves as one and anything above
  // the maximum behaves as the maximum.
  function automatic int active_coefs();
    if (coef_cfg < 1) return 1;
    if (coef_cfg > MAX_COEFS) return MAX_COEFS;
    return coef_cfg;
  endfunction

  // History entry written 'back' frames before the current one, for one
  // coefficient. A back offset of four lands on the current slot, which
  // still holds the frame from four frames ago until it is overwritten.
  function automatic logic signed [cdf_pkg::CEP_W-1:0] hist_at(input int back,
                                                              input int c);
    int slot;
    slot = (hist_slot + SLOTS - (back % SLOTS)) % SLOTS;
    return cep_hist[slot][c];
  endfunction

  // Works out every result that one accepted coefficient word releases and
  // queues them in order, then advances the history and the counters.
  task automatic predict_deltas(input logic signed [cdf_pkg::CEP_W-1:0] cur,
                                input logic fin);
    int                                 c;
    int                                 f;
    int                                 bstart;
    int                                 bend;
    int                                 back;
    bit                                 is_last;
    bit                                 shortcase;
    bit                                 lead;
    logic signed [cdf_pkg::DELTA_W-1:0] d;
    feature_t                           r;
    c         = coef_ctr;
    f         = frame_ctr;
    is_last   = (c + 1) >= active_coefs();
    shortcase = !have_history && f < SLOTS;
    lead      = !have_history && f == SLOTS;
    d         = '0;
    if (!shortcase) d = cdf_pkg::DELTA_W'(int'(cur) - int'(hist_at(SLOTS, c)));
    // The frame that first completes the window also releases the lead-in
    // frames; a final word releases the tail frames down to itself.
    bstart = (shortcase || lead) ? f : HALF_WIN;
    bend   = fin ? 0 : HALF_WIN;
    if (!(shortcase && !fin)) begin
      for (back = bstart; back >= bend; back--) begin
        r.frame = cdf_pkg::FRAME_W'(f - back);
        r.coef  = cdf_pkg::COEF_W'(c);
        r.cep   = (back == 0) ? cur : hist_at(back, c);
        r.delta = shortcase ? '0 : d;
        r.uend  = fin && is_last && (back == bend);
        r.serr  = shortcase;
        pending_features.push_back(r);
      end
    end
    cep_hist[hist_slot][c] = cur;
    if (!is_last) begin
      coef_ctr = cdf_pkg::COEF_W'(c + 1);
    end else begin
      coef_ctr = '0;
      // The utterance only closes when the flag sits on the frame's last
      // coefficient; anywhere else the frame simply moves on.
      if (fin) begin
        frame_ctr    = '0;
        hist_slot    = '0;
        have_history = 1'b0;
      end else begin
        if (f >= SLOTS) have_history = 1'b1;
        frame_ctr = frame_ctr + 1'b1;
        hist_slot = hist_slot + 1'b1;
      end
    end
  endtask

  // Random coefficient, with the sign extremes, zero and minus one thrown in
  // often enough to matter.
  function automatic logic signed [cdf_pkg::CEP_W-1:0] rand_cep();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      3:       return -16'sd1;
      default: return cdf_pkg::CEP_W'($urandom);
    endcase
  endfunction

  // Offers one coefficient word and holds it until the block takes it. Called
  // at a falling edge and returns at a falling edge with push lowered, so a
  // following call raises it again within the same step.
  task automatic put_coef(input logic signed [cdf_pkg::CEP_W-1:0] v, input logic fin);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    push           = 1'b1;
    in_cep_value   = v;
    in_final_frame = fin;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_deltas(v, fin);
    coef_words_sent++;
    @(negedge clk);
    push = 1'b0;
  endtask

  // Waits for every expected result, then lets the pipeline settle so that
  // words which release nothing have also left it.
  task automatic wait_drained();
    int spins;
    spins = 0;
    while (pending_features.size() != 0 && spins < DRAIN_SPIN) begin
      @(negedge clk);
      spins++;
    end
    if (pending_features.size() != 0) begin
      $error("%0d expected results never arrived", pending_features.size());
      mismatch_count++;
      pending_features.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // Only ever called with the block drained, at a falling edge.
  task automatic write_coef_count(input logic [cdf_pkg::CFG_W-1:0] v);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    coef_cfg    = v;
  endtask

  // A full utterance at the current count. A noisy one carries one stray
  // final flag on some coefficient of an earlier frame.
  task automatic run_utterance(input int frames, input bit noisy);
    int n;
    int fr;
    int c;
    int stray_f;
    int stray_c;
    n       = active_coefs();
    stray_f = (noisy && frames > 1) ? $urandom_range(0, frames - 2) : -1;
    stray_c = $urandom_range(0, n - 1);
    for (fr = 0; fr < frames; fr++) begin
      for (c = 0; c < n; c++) begin
        put_coef(rand_cep(), (fr == frames - 1) || (fr == stray_f && c == stray_c));
      end
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: stalls come in bursts while idling is on.
  always @(negedge clk) begin
    if (idle_on && pop_stall == 0 && $urandom_range(0, 11) == 0) begin
      pop_stall = $urandom_range(1, 15);
    end
    if (pop_stall > 0) begin
      pop = 1'b0;
      pop_stall--;
    end else begin
      pop = 1'b1;
    end
  end

  // Every result taken is compared with the oldest expectation.
  always @(posedge clk) begin
    feature_t want;
    if (rst_n && pop && !empty) begin
      if (pending_features.size() == 0) begin
        $error("unexpected result: frame %0d coef %0d", out_frame_index, out_coef_index);
        mismatch_count++;
      end else begin
        want = pending_features.pop_front();
        check_field("frame_index", want.frame, out_frame_index);
        check_field("coef_index", want.coef, out_coef_index);
        check_field("cep_out", want.cep, out_cep_out);
        check_field("delta_out", want.delta, out_delta_out);
        check_field("utterance_end", want.uend, out_utterance_end);
        check_field("short_error", want.serr, out_short_error);
        features_checked++;
      end
    end
  end

  // The reset count of thirteen, then both out-of-range settings, each in a
  // single-frame utterance so that every result is a short one.
  task automatic test_coef_count_limits();
    run_utterance(1, 1'b0);
    wait_drained();
    write_coef_count(6'd63);
    run_utterance(1, 1'b0);
    wait_drained();
    write_coef_count(6'd0);
    run_utterance(1, 1'b0);
    wait_drained();
  endtask

  // Utterances that end before the window ever fills: the last frame
  // releases all of its predecessors with zero deltas.
  task automatic test_short_utterances();
    write_coef_count(6'd1);
    put_coef(16'sh7fff, 1'b0);
    put_coef(16'sh8000, 1'b1);
    put_coef(16'sh8000, 1'b0);
    put_coef(16'sh7fff, 1'b0);
    put_coef(-16'sd1, 1'b0);
    put_coef(16'sh0100, 1'b1);
    wait_drained();
  endtask

  // Largest positive and negative deltas, through the lead-in frame and a
  // steady frame that then closes the utterance.
  task automatic test_delta_extremes();
    put_coef(16'sh8000, 1'b0);
    put_coef(16'sh7fff, 1'b0);
    put_coef('0, 1'b0);
    put_coef(-16'sd1, 1'b0);
    put_coef(16'sh7fff, 1'b0);
    put_coef(16'sh8000, 1'b1);
    wait_drained();
  endtask

  // The final flag on the first coefficient of an early frame only: that
  // coefficient gets its tail released but the utterance carries on.
  task automatic test_stray_final_flag();
    int fr;
    write_coef_count(6'd2);
    for (fr = 0; fr < 5; fr++) begin
      put_coef(rand_cep(), fr == 1 || fr == 4);
      put_coef(rand_cep(), fr == 4);
    end
    wait_drained();
  endtask

  // Count lowered in the middle of a frame: the next word sits beyond the new
  // count and so closes the frame. Only a lowering is safe here, as a raise
  // would read history that was never written.
  task automatic test_mid_frame_shrink();
    int fr;
    int c;
    write_coef_count(6'd3);
    for (fr = 0; fr < 5; fr++) begin
      for (c = 0; c < 3; c++) put_coef(rand_cep(), 1'b0);
    end
    put_coef(rand_cep(), 1'b0);
    put_coef(rand_cep(), 1'b0);
    wait_drained();
    write_coef_count(6'd1);
    put_coef(rand_cep(), 1'b0);
    put_coef(rand_cep(), 1'b1);
    wait_drained();
  endtask

  // Mostly well-formed utterances of random length and content, some short,
  // some with a stray final flag, across a range of small counts.
  task automatic test_random_utterances();
    int start;
    int frames;
    idle_on = 1'b1;
    start   = coef_words_sent;
    while (coef_words_sent - start < RAND_WORDS) begin
      write_coef_count(cdf_pkg::CFG_W'($urandom_range(0, 6)));
      repeat ($urandom_range(1, 3)) begin
        frames = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
        run_utterance(frames, $urandom_range(0, 3) == 0);
      end
      wait_drained();
    end
    idle_on = 1'b0;
  endtask

  // One steady utterance with no idle gaps offered on either side.
  task automatic test_back_to_back();
    write_coef_count(6'd4);
    run_utterance(7, 1'b0);
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    in_cep_value     = '0;
    in_final_frame   = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    idle_on          = 1'b0;
    pop_stall        = 0;
    coef_words_sent  = 0;
    features_checked = 0;
    mismatch_count   = 0;
    frame_ctr        = '0;
    coef_ctr         = '0;
    hist_slot        = '0;
    have_history     = 1'b0;
    coef_cfg         = cdf_pkg::COEF_COUNT_RESET;
    foreach (cep_hist[s, c]) cep_hist[s][c] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_coef_count_limits();
    test_short_utterances();
    test_delta_extremes();
    test_stray_final_flag();
    test_mid_frame_shrink();
    test_random_utterances();
    test_back_to_back();

    $display("Sent %0d coefficient words and checked %0d feature results.",
             coef_words_sent, features_checked);
    $display("Covered counts 0 to 63, short and stray-flag utterances, a mid-frame");
    $display("shrink, stalls on both sides and an unstalled stream at the end.");
    if (mismatch_count == 0) begin
      $display("cepstral_delta_features_unit test passed");
    end else begin
      $display("cepstral_delta_features_unit test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even with every word stalled at length.
  initial begin
    #2000000;
    $display("cepstral_delta_features_unit test failed");
    $finish;
  end

endmodule
